>>> hw/rtl/bmp_scanline_pixel_unpacker_top_defines.svh
// Assertion helpers shared by the unpacker RTL.
`ifndef BMP_SCANLINE_PIXEL_UNPACKER_TOP_DEFINES_SVH
`define BMP_SCANLINE_PIXEL_UNPACKER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSPU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bspu assertion failed");

// Next-cycle implication, checked outside reset.
`define BSPU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bspu assertion failed");

`endif

>>> hw/rtl/bspu_pkg.sv
`default_nettype none
package bspu_pkg;

   localparam int CFG_W       = 12;
   localparam int DEPTH_W     = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int REQ_TYPE_W  = 2;
   localparam int PAL_IDX_W   = 8;
   localparam int BYTE_W      = 8;
   localparam int COLOR_W     = 24;
   localparam int XY_W        = 13;
   localparam int CNT_W       = 4;
   localparam int LANE_W      = 3;
   localparam int PHASE_W     = 2;

   localparam int DEF_MAX_WIDTH       = 2048;
   localparam int DEF_MAX_HEIGHT      = 2048;
   localparam int DEF_PALETTE_ENTRIES = 256;
   localparam int QUEUE_DEPTH         = 4;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_PAL_WRITE = 2'd0,
      REQ_DATA      = 2'd1,
      REQ_RESTART   = 2'd2,
      REQ_NONE      = 2'd3
   } req_kind_type;

   typedef enum logic [DEPTH_W-1:0] {
      DEPTH_1  = 3'd0,
      DEPTH_4  = 3'd1,
      DEPTH_8  = 3'd2,
      DEPTH_16 = 3'd3,
      DEPTH_24 = 3'd4,
      DEPTH_32 = 3'd5
   } depth_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEPTH       = 3'd0,
      CSR_IMG_WIDTH   = 3'd1,
      CSR_DRAW_WIDTH  = 3'd2,
      CSR_DRAW_HEIGHT = 3'd3,
      CSR_ORIGIN_X    = 3'd4,
      CSR_ORIGIN_Y    = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      MODE_IDX1   = 2'd0,
      MODE_IDX4   = 2'd1,
      MODE_IDX8   = 2'd2,
      MODE_DIRECT = 2'd3
   } mode_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [CFG_W-1:0]   image_width;
      logic [CFG_W-1:0]   draw_width;
      logic [CFG_W-1:0]   draw_height;
      logic [CFG_W-1:0]   origin_x;
      logic [CFG_W-1:0]   origin_y;
   } bspu_cfg_type;

   // One queue entry: a palette write (data = index) or one byte's pixel run.
   typedef struct packed {
      logic               is_write;
      mode_type           mode;
      logic [BYTE_W-1:0]  data;
      logic [COLOR_W-1:0] color;
      logic [XY_W-1:0]    x;
      logic [XY_W-1:0]    y;
      logic [CNT_W-1:0]   count;
   } bspu_job_type;

   function automatic logic [COLOR_W-1:0] rgb565_to_888(input logic [15:0] v);
      return {v[15:11], 3'b000, v[10:5], 2'b00, v[4:0], 3'b000};
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bmp_scanline_pixel_unpacker_top.sv
// A data byte accepted on req_ passes the queue, the current-job register and the output
// register before its first pixel shows on rsp_. With no stall on either side, one item
// per cycle at 8, 16, 24 and 32 bpp; a 1 bpp byte gives up to 8 pixels, a 4 bpp byte up
// to 2, one per palette RAM read; a 4-deep queue decouples front from back.
// Reset (synchronous, active high): registers to defaults, frame finished, queue empty;
// palette contents are undefined until written, no clearing pass.
`default_nettype none
module bmp_scanline_pixel_unpacker_top #(
   parameter int MAX_WIDTH       = bspu_pkg::DEF_MAX_WIDTH,
   parameter int PALETTE_ENTRIES = bspu_pkg::DEF_PALETTE_ENTRIES,
   parameter int MAX_HEIGHT      = bspu_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input beats
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [bspu_pkg::REQ_TYPE_W-1:0]   req_type,
   input  wire logic [bspu_pkg::PAL_IDX_W-1:0]    req_pal_index,
   input  wire logic [bspu_pkg::COLOR_W-1:0]      req_pal_color,
   input  wire logic [bspu_pkg::BYTE_W-1:0]       req_data_byte,
   // pixel beats
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [bspu_pkg::XY_W-1:0]              rsp_pix_x,
   output logic [bspu_pkg::XY_W-1:0]              rsp_pix_y,
   output logic [bspu_pkg::COLOR_W-1:0]           rsp_pix_color,
   output logic                                   rsp_last_of_byte,
   // register writes
   input  wire logic                              csr_we,
   input  wire logic [bspu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bspu_pkg::CFG_W-1:0]        csr_wdata
);
   import bspu_pkg::*;

   bspu_cfg_type cfg_ff, cfg_in;
   logic         push, queue_full, q_valid, q_pop;
   bspu_job_type push_job, head_job;

   // Register file: write-only, indexes beyond the list drop the write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEPTH:       cfg_in.depth       = csr_wdata[DEPTH_W-1:0];
            CSR_IMG_WIDTH:   cfg_in.image_width = csr_wdata;
            CSR_DRAW_WIDTH:  cfg_in.draw_width  = csr_wdata;
            CSR_DRAW_HEIGHT: cfg_in.draw_height = csr_wdata;
            CSR_ORIGIN_X:    cfg_in.origin_x    = csr_wdata;
            CSR_ORIGIN_Y:    cfg_in.origin_y    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth       <= DEPTH_8;
         cfg_ff.image_width <= CFG_W'(1);
         cfg_ff.draw_width  <= '0;
         cfg_ff.draw_height <= '0;
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: classify each beat, track row/column position, assemble
   // multi-byte pixels, and queue a palette write or a run of drawn pixels.
   bspu_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_pal_index (req_pal_index),
      .req_pal_color (req_pal_color),
      .req_data_byte (req_data_byte),
      .push          (push),
      .push_job      (push_job),
      .queue_full    (queue_full)
   );

   // Short queue: keeps palette writes in order with the pixel runs around them.
   bspu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_job  (head_job)
   );

   // Back end: apply palette writes, expand runs one pixel a cycle through the
   // palette RAM while the output is not stalled, and hold the result in the output register.
   bspu_back #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_job            (head_job),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pix_x        (rsp_pix_x),
      .rsp_pix_y        (rsp_pix_y),
      .rsp_pix_color    (rsp_pix_color),
      .rsp_last_of_byte (rsp_last_of_byte)
   );
endmodule
`default_nettype wire

>>> hw/rtl/bspu_ram.sv
`default_nettype none
module bspu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/bspu_queue.sv
`default_nettype none
`include "bmp_scanline_pixel_unpacker_top_defines.svh"
module bspu_queue #(
   parameter int DEPTH = bspu_pkg::QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire bspu_pkg::bspu_job_type push_job,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       not_empty,
   output bspu_pkg::bspu_job_type     head_job
);
   import bspu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   bspu_job_type      slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_QW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `BSPU_ASSERT_IMPL(a_no_overflow, clock, reset, push, !full)
   `BSPU_ASSERT_IMPL(a_no_underflow, clock, reset, pop, not_empty)
   `BSPU_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1)
endmodule
`default_nettype wire

>>> hw/rtl/bspu_front.sv
`default_nettype none
module bspu_front #(
   parameter int MAX_WIDTH  = bspu_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bspu_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire bspu_pkg::bspu_cfg_type                cfg,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [bspu_pkg::REQ_TYPE_W-1:0]       req_type,
   input  wire logic [bspu_pkg::PAL_IDX_W-1:0]        req_pal_index,
   input  wire logic [bspu_pkg::COLOR_W-1:0]          req_pal_color,
   input  wire logic [bspu_pkg::BYTE_W-1:0]           req_data_byte,
   output logic                                       push,
   output bspu_pkg::bspu_job_type                     push_job,
   input  wire logic                                  queue_full
);
   import bspu_pkg::*;

   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int CW     = (WID_W > CFG_W) ? WID_W : CFG_W;
   localparam int COL_W  = CW + 1;
   localparam int BIR_W  = CW + 2;
   localparam int STR_W  = CW + 6;
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int HGT_W0 = $clog2(MAX_HEIGHT + 1);
   localparam int HC     = (HGT_W0 > CFG_W) ? HGT_W0 : CFG_W;
   localparam int XS_W   = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
   localparam int YS_W   = ((ROW_W > CFG_W) ? ROW_W : CFG_W) + 1;

   logic [ROW_W-1:0]   row_ff, row_in;
   logic [BIR_W-1:0]   bir_ff, bir_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [COLOR_W-1:0] partial_ff, partial_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               done_ff, done_in;

   logic               accept;
   logic [CW-1:0]      img_w, eff_w, drw, dw_eff;
   logic [STR_W-1:0]   ew, row_bits, stride;
   logic [HC-1:0]      hgt, h_sat;
   logic [ROW_W-1:0]   restart_row;
   logic               restart_done;
   logic               emit;
   mode_type           emode;
   logic [COLOR_W-1:0] ecolor, acc, partial_nx;
   logic [PHASE_W-1:0] phase_nx;
   logic [PHASE_W:0]   phase_inc;
   logic [CNT_W-1:0]   ppb, count;
   logic [COL_W-1:0]   dw_c, rem, col_adv;
   logic [BIR_W-1:0]   bir_inc;
   logic               row_end;
   logic [XS_W-1:0]    xsum;
   logic [YS_W-1:0]    ysum;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // Effective geometry from the registers.
   always_comb begin
      img_w = CW'(cfg.image_width);
      if (img_w == '0) begin
         eff_w = CW'(1);
      end else if (img_w > CW'(MAX_WIDTH)) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = img_w;
      end
      drw    = CW'(cfg.draw_width);
      dw_eff = (drw > eff_w) ? eff_w : drw;
      ew     = STR_W'(eff_w);
      case (cfg.depth)
         DEPTH_1:  row_bits = ew;
         DEPTH_4:  row_bits = ew << 2;
         DEPTH_16: row_bits = ew << 4;
         DEPTH_24: row_bits = (ew << 4) + (ew << 3);
         DEPTH_32: row_bits = ew << 5;
         default:  row_bits = ew << 3;
      endcase
      stride = ((row_bits + STR_W'(31)) >> 5) << 2;
      hgt    = HC'(cfg.draw_height);
      h_sat  = (hgt > HC'(MAX_HEIGHT)) ? HC'(MAX_HEIGHT) : hgt;
      restart_done = (h_sat == '0);
      restart_row  = restart_done ? '0 : ROW_W'(h_sat - HC'(1));
   end

   // Decode one data byte.
   always_comb begin
      emit       = 1'b0;
      emode      = MODE_IDX8;
      ecolor     = '0;
      ppb        = CNT_W'(1);
      partial_nx = partial_ff;
      phase_nx   = phase_ff;
      acc        = partial_ff | (COLOR_W'(req_data_byte) << {phase_ff, 3'b000});
      phase_inc  = {1'b0, phase_ff} + (PHASE_W + 1)'(1);
      case (cfg.depth)
         DEPTH_1: begin
            emit  = 1'b1;
            emode = MODE_IDX1;
            ppb   = CNT_W'(8);
         end
         DEPTH_4: begin
            emit  = 1'b1;
            emode = MODE_IDX4;
            ppb   = CNT_W'(2);
         end
         DEPTH_16: begin
            emode = MODE_DIRECT;
            if (phase_ff == '0) begin
               partial_nx = COLOR_W'(req_data_byte);
               phase_nx   = PHASE_W'(1);
            end else begin
               emit       = 1'b1;
               ecolor     = rgb565_to_888({req_data_byte, partial_ff[7:0]});
               partial_nx = '0;
               phase_nx   = '0;
            end
         end
         DEPTH_24, DEPTH_32: begin
            emode = MODE_DIRECT;
            if (phase_inc >= ((cfg.depth == DEPTH_24) ? 3'd3 : 3'd4)) begin
               emit       = 1'b1;
               ecolor     = acc;
               partial_nx = '0;
               phase_nx   = '0;
            end else begin
               partial_nx = acc;
               phase_nx   = phase_inc[PHASE_W-1:0];
            end
         end
         default: begin
            emit  = 1'b1;
            emode = MODE_IDX8;
         end
      endcase

      dw_c = COL_W'(dw_eff);
      rem  = dw_c - col_ff;
      if (emit && (col_ff < dw_c)) begin
         count = (rem < COL_W'(ppb)) ? CNT_W'(rem) : ppb;
      end else begin
         count = '0;
      end
      col_adv = emit ? col_ff + COL_W'(ppb) : col_ff;
      bir_inc = bir_ff + BIR_W'(1);
      row_end = (STR_W'(bir_inc) >= stride);
      xsum    = XS_W'(col_ff) + XS_W'(cfg.origin_x);
      ysum    = YS_W'(row_ff) + YS_W'(cfg.origin_y);
   end

   // Queue entry and position update.
   always_comb begin
      push              = 1'b0;
      push_job.is_write = 1'b0;
      push_job.mode     = emode;
      push_job.data     = req_data_byte;
      push_job.color    = ecolor;
      push_job.x        = xsum[XY_W-1:0];
      push_job.y        = ysum[XY_W-1:0];
      push_job.count    = count;
      row_in     = row_ff;
      bir_in     = bir_ff;
      col_in     = col_ff;
      partial_in = partial_ff;
      phase_in   = phase_ff;
      done_in    = done_ff;
      if (accept) begin
         case (req_type)
            REQ_PAL_WRITE: begin
               push              = 1'b1;
               push_job.is_write = 1'b1;
               push_job.data     = req_pal_index;
               push_job.color    = req_pal_color;
               push_job.count    = '0;
            end
            REQ_RESTART: begin
               row_in     = restart_row;
               done_in    = restart_done;
               bir_in     = '0;
               col_in     = '0;
               partial_in = '0;
               phase_in   = '0;
            end
            REQ_DATA: begin
               if (!done_ff) begin
                  push = (count != '0);
                  if (row_end) begin
                     bir_in     = '0;
                     col_in     = '0;
                     partial_in = '0;
                     phase_in   = '0;
                     if (row_ff == '0) begin
                        done_in = 1'b1;
                     end else begin
                        row_in = row_ff - ROW_W'(1);
                     end
                  end else begin
                     bir_in     = bir_inc;
                     col_in     = col_adv;
                     partial_in = partial_nx;
                     phase_in   = phase_nx;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Reset draw height is zero: the frame starts out finished.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         bir_ff     <= '0;
         col_ff     <= '0;
         partial_ff <= '0;
         phase_ff   <= '0;
         done_ff    <= 1'b1;
      end else begin
         row_ff     <= row_in;
         bir_ff     <= bir_in;
         col_ff     <= col_in;
         partial_ff <= partial_in;
         phase_ff   <= phase_in;
         done_ff    <= done_in;
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/bspu_back.sv
`default_nettype none
`include "bmp_scanline_pixel_unpacker_top_defines.svh"
module bspu_back #(
   parameter int PALETTE_ENTRIES = bspu_pkg::DEF_PALETTE_ENTRIES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   input  wire bspu_pkg::bspu_job_type          q_job,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [bspu_pkg::XY_W-1:0]            rsp_pix_x,
   output logic [bspu_pkg::XY_W-1:0]            rsp_pix_y,
   output logic [bspu_pkg::COLOR_W-1:0]         rsp_pix_color,
   output logic                                 rsp_last_of_byte
);
   import bspu_pkg::*;

   localparam int AW  = $clog2(PALETTE_ENTRIES);
   localparam int PW0 = $clog2(PALETTE_ENTRIES + 1);
   localparam int PW  = (PW0 > PAL_IDX_W) ? PW0 : PAL_IDX_W;

   bspu_job_type       cur_ff, cur_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [LANE_W-1:0]  k_ff, k_in;
   logic               b_valid_ff, b_valid_in;
   logic [XY_W-1:0]    b_x_ff, b_y_ff;
   logic [COLOR_W-1:0] b_color_ff;
   logic               b_direct_ff, b_zero_ff, b_last_ff;

   logic               b_adv, issue, is_last, last_issue;
   logic [PAL_IDX_W-1:0] idx;
   logic               idx_ok, wr_ok, pal_we;
   logic [COLOR_W-1:0] ram_q;

   assign b_adv      = !b_valid_ff || !rsp_stall;
   assign issue      = cur_valid_ff && b_adv;
   assign is_last    = ((CNT_W'(k_ff) + CNT_W'(1)) == cur_ff.count);
   assign last_issue = issue && is_last;
   assign q_pop      = q_valid && (!cur_valid_ff || last_issue);
   assign wr_ok      = (PW'(q_job.data) < PW'(PALETTE_ENTRIES));
   assign pal_we     = q_pop && q_job.is_write && wr_ok;
   assign idx_ok     = (PW'(idx) < PW'(PALETTE_ENTRIES));

   // Palette index of lane k.
   always_comb begin
      case (cur_ff.mode)
         MODE_IDX1: idx = {7'b0, cur_ff.data[3'd7 - k_ff]};
         MODE_IDX4: idx = k_ff[0] ? {4'b0, cur_ff.data[3:0]} : {4'b0, cur_ff.data[7:4]};
         default:   idx = cur_ff.data;
      endcase
   end

   bspu_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock (clock),
      .we    (pal_we),
      .waddr (q_job.data[AW-1:0]),
      .wdata (q_job.color),
      .re    (issue),
      .raddr (idx[AW-1:0]),
      .rdata (ram_q)
   );

   // Sequencer: one pixel per cycle out of the current job, while the output register can advance.
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      k_in         = k_ff;
      if (issue && !is_last) begin
         k_in = k_ff + LANE_W'(1);
      end
      if (last_issue) begin
         cur_valid_in = 1'b0;
      end
      if (q_pop) begin
         if (q_job.is_write) begin
            cur_valid_in = 1'b0;
         end else begin
            cur_in       = q_job;
            cur_valid_in = 1'b1;
            k_in         = '0;
         end
      end
      b_valid_in = issue ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         k_ff         <= '0;
         b_valid_ff   <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         k_ff         <= k_in;
         b_valid_ff   <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (issue) begin
         b_x_ff      <= cur_ff.x + XY_W'(k_ff);
         b_y_ff      <= cur_ff.y;
         b_color_ff  <= cur_ff.color;
         b_direct_ff <= (cur_ff.mode == MODE_DIRECT);
         b_zero_ff   <= !idx_ok;
         b_last_ff   <= is_last;
      end
   end

   assign rsp_valid        = b_valid_ff;
   assign rsp_pix_x        = b_x_ff;
   assign rsp_pix_y        = b_y_ff;
   assign rsp_last_of_byte = b_last_ff;
   assign rsp_pix_color    = b_direct_ff ? b_color_ff : (b_zero_ff ? '0 : ram_q);

   `BSPU_ASSERT_IMPL(a_job_nonempty, clock, reset, cur_valid_ff, cur_ff.count != '0)
   `BSPU_ASSERT_IMPL(a_lane_in_run, clock, reset, cur_valid_ff, CNT_W'(k_ff) < cur_ff.count)
   `BSPU_ASSERT_NEXT(a_run_continues, clock, reset, issue && !is_last, cur_valid_ff)
endmodule
`default_nettype wire

>>> tb/sv/bmp_scanline_pixel_unpacker_top_tb.sv
`default_nettype none
module bmp_scanline_pixel_unpacker_top_tb;
   import bspu_pkg::*;

   // Depth code with no name of its own; the block treats it as 8 bpp.
   localparam logic [DEPTH_W-1:0] DEPTH_SPARE = 3'd7;
   // Cycles with no beat on either channel before the run is called hung.
   localparam int QUIET_LIMIT = 3000;
   // Pipeline depth plus a full queue of 1 bpp bytes still draining.
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      req_kind_type       kind;
      logic [PAL_IDX_W-1:0] pal_index;
      logic [COLOR_W-1:0] pal_color;
      logic [BYTE_W-1:0]  data;
   } byte_beat_type;

   typedef struct packed {
      logic [XY_W-1:0]    x;
      logic [XY_W-1:0]    y;
      logic [COLOR_W-1:0] color;
      logic               last_of_byte;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [REQ_TYPE_W-1:0] req_type = REQ_NONE;
   logic [PAL_IDX_W-1:0]  req_pal_index = '0;
   logic [COLOR_W-1:0]    req_pal_color = '0;
   logic [BYTE_W-1:0]     req_data_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [XY_W-1:0]       rsp_pix_x;
   logic [XY_W-1:0]       rsp_pix_y;
   logic [COLOR_W-1:0]    rsp_pix_color;
   logic                  rsp_last_of_byte;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_DEPTH;
   logic [CFG_W-1:0]      csr_wdata = '0;

   bmp_scanline_pixel_unpacker_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_pal_index    (req_pal_index),
      .req_pal_color    (req_pal_color),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pix_x        (rsp_pix_x),
      .rsp_pix_y        (rsp_pix_y),
      .rsp_pix_color    (rsp_pix_color),
      .rsp_last_of_byte (rsp_last_of_byte),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow of the unpacker: register copy, palette and frame position.
   // ---------------------------------------------------------------------
   logic [DEPTH_W-1:0] cfg_depth;
   int                 cfg_img_w, cfg_draw_w, cfg_draw_h, cfg_org_x, cfg_org_y;
   logic [COLOR_W-1:0] palette_mem [DEF_PALETTE_ENTRIES];
   int                 row_idx, byte_pos, pix_col, byte_slot;
   logic [COLOR_W-1:0] partial_rgb;
   logic               frame_over;

   pixel_type     expected_pixels [$];
   byte_beat_type pending_beats [$];
   byte_beat_type cur_beat;

   int beats_queued = 0;
   int beats_accepted = 0;
   int pixels_checked = 0;
   int mismatch_count = 0;
   int frame_setups = 0;
   int sender_gap_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   function automatic int depth_bits(input logic [DEPTH_W-1:0] code);
      case (code)
         DEPTH_1:  return 1;
         DEPTH_4:  return 4;
         DEPTH_16: return 16;
         DEPTH_24: return 24;
         DEPTH_32: return 32;
         default:  return 8;
      endcase
   endfunction

   // Stored width with zero lifted to one and the top clipped.
   function automatic int image_cols();
      if (cfg_img_w == 0) return 1;
      if (cfg_img_w > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return cfg_img_w;
   endfunction

   // Row stride in bytes, padded to a 32-bit boundary.
   function automatic int stride_bytes();
      return ((depth_bits(cfg_depth) * image_cols() + 31) >> 5) << 2;
   endfunction

   function automatic void restart_frame();
      int h;
      h = (cfg_draw_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cfg_draw_h;
      byte_pos    = 0;
      pix_col     = 0;
      partial_rgb = '0;
      byte_slot   = 0;
      frame_over  = (h == 0);
      row_idx     = (h == 0) ? 0 : h - 1;
   endfunction

   function automatic void reset_model();
      cfg_depth  = DEPTH_8;
      cfg_img_w  = 1;
      cfg_draw_w = 0;
      cfg_draw_h = 0;
      cfg_org_x  = 0;
      cfg_org_y  = 0;
      foreach (palette_mem[i]) palette_mem[i] = '0;
      restart_frame();
   endfunction

   // Queue a pixel if its column is drawn; advance the column either way.
   function automatic void push_pixel(input logic [COLOR_W-1:0] rgb);
      pixel_type p;
      int        drawn;
      drawn = (cfg_draw_w > image_cols()) ? image_cols() : cfg_draw_w;
      if (pix_col < drawn) begin
         p.x            = XY_W'(pix_col + cfg_org_x);
         p.y            = XY_W'(row_idx + cfg_org_y);
         p.color        = rgb;
         p.last_of_byte = 1'b0;
         expected_pixels.push_back(p);
      end
      pix_col++;
   endfunction

   // Work out the pixels one accepted beat produces.
   function automatic void unpack_beat(input byte_beat_type b);
      int           bits;
      int           first;
      logic [15:0]  v565;
      pixel_type    tail;
      bits  = depth_bits(cfg_depth);
      first = expected_pixels.size();
      case (b.kind)
         REQ_PAL_WRITE: palette_mem[b.pal_index] = b.pal_color;
         REQ_RESTART:   restart_frame();
         REQ_DATA: begin
            if (!frame_over) begin
               case (bits)
                  1: begin
                     for (int k = 7; k >= 0; k--) push_pixel(palette_mem[b.data[k]]);
                  end
                  4: begin
                     push_pixel(palette_mem[b.data[7:4]]);
                     push_pixel(palette_mem[b.data[3:0]]);
                  end
                  8: push_pixel(palette_mem[b.data]);
                  16: begin
                     if (byte_slot == 0) begin
                        partial_rgb = COLOR_W'(b.data);
                        byte_slot   = 1;
                     end else begin
                        v565 = {b.data, partial_rgb[7:0]};
                        push_pixel({v565[15:11], 3'b000, v565[10:5], 2'b00, v565[4:0], 3'b000});
                        byte_slot   = 0;
                        partial_rgb = '0;
                     end
                  end
                  default: begin
                     // 24 / 32 bpp: B, G, R little-endian; drop the alpha byte.
                     if (byte_slot < 3)
                        partial_rgb = partial_rgb | (COLOR_W'(b.data) << (8 * byte_slot));
                     byte_slot++;
                     if (byte_slot >= bits / 8) begin
                        push_pixel(partial_rgb);
                        byte_slot   = 0;
                        partial_rgb = '0;
                     end
                  end
               endcase
               // Tag the final pixel of this byte.
               if (expected_pixels.size() > first) begin
                  tail = expected_pixels.pop_back();
                  tail.last_of_byte = 1'b1;
                  expected_pixels.push_back(tail);
               end
               // Close the row once the stride is consumed; drop any partial pixel.
               byte_pos++;
               if (byte_pos >= stride_bytes()) begin
                  byte_pos    = 0;
                  pix_col     = 0;
                  partial_rgb = '0;
                  byte_slot   = 0;
                  if (row_idx == 0) frame_over = 1'b1;
                  else row_idx--;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Driver: present queued beats, hold while stalled, idle at random.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      logic fire;
      fire = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            unpack_beat(cur_beat);
            beats_accepted++;
         end
         // A stalled beat stays put; otherwise load the next one or go idle.
         if (!req_valid || fire) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
               cur_beat = pending_beats.pop_front();
               req_valid     <= 1'b1;
               req_type      <= cur_beat.kind;
               req_pal_index <= cur_beat.pal_index;
               req_pal_color <= cur_beat.pal_color;
               req_data_byte <= cur_beat.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare every accepted pixel beat with the oldest expectation.
   // ---------------------------------------------------------------------
   task automatic flag_pixel(input string field, input logic [31:0] got,
                             input logic [31:0] want);
      if (mismatch_count < 40)
         $display("mismatch: %s on pixel beat %0d, got 'h%0h want 'h%0h",
                  field, pixels_checked, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_rsp
      pixel_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               flag_pixel("pixel with none pending", 32'({rsp_pix_y, rsp_pix_x}), '0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pix_x !== want.x)
                  flag_pixel("pix_x", 32'(rsp_pix_x), 32'(want.x));
               if (rsp_pix_y !== want.y)
                  flag_pixel("pix_y", 32'(rsp_pix_y), 32'(want.y));
               if (rsp_pix_color !== want.color)
                  flag_pixel("pix_color", 32'(rsp_pix_color), 32'(want.color));
               if (rsp_last_of_byte !== want.last_of_byte)
                  flag_pixel("last_of_byte", 32'(rsp_last_of_byte), 32'(want.last_of_byte));
            end
            pixels_checked++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL bmp_scanline_pixel_unpacker_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------
   task automatic queue_beat(input req_kind_type kind, input logic [BYTE_W-1:0] data,
                             input logic [PAL_IDX_W-1:0] idx,
                             input logic [COLOR_W-1:0] color);
      byte_beat_type b;
      b.kind      = kind;
      b.data      = data;
      b.pal_index = idx;
      b.pal_color = color;
      pending_beats.push_back(b);
      beats_queued++;
   endtask

   // Queue a beat with the given data byte and a random palette index and color.
   task automatic queue_kind(input req_kind_type kind, input logic [BYTE_W-1:0] data);
      queue_beat(kind, data, PAL_IDX_W'($urandom), COLOR_W'($urandom));
   endtask

   // Wait until every beat is taken and every pixel seen, then let the back end settle.
   task automatic drain();
      while (beats_accepted != beats_queued || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CFG_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_DEPTH:       cfg_depth  = DEPTH_W'(value);
         CSR_IMG_WIDTH:   cfg_img_w  = value & 12'hFFF;
         CSR_DRAW_WIDTH:  cfg_draw_w = value & 12'hFFF;
         CSR_DRAW_HEIGHT: cfg_draw_h = value & 12'hFFF;
         CSR_ORIGIN_X:    cfg_org_x  = value & 12'hFFF;
         CSR_ORIGIN_Y:    cfg_org_y  = value & 12'hFFF;
         default: ;
      endcase
   endtask

   // Drain, reprogram all registers, and pick the idling style for the next phase.
   task automatic set_frame(input logic [DEPTH_W-1:0] depth, input int img_w,
                            input int draw_w, input int draw_h,
                            input int org_x, input int org_y);
      drain();
      write_csr(CSR_DEPTH, depth);
      write_csr(CSR_IMG_WIDTH, img_w);
      write_csr(CSR_DRAW_WIDTH, draw_w);
      write_csr(CSR_DRAW_HEIGHT, draw_h);
      write_csr(CSR_ORIGIN_X, org_x);
      write_csr(CSR_ORIGIN_Y, org_y);
      @(negedge clock);
      case (frame_setups % 4)
         0: begin sender_gap_pct = 0;  stall_pct = 0;  end
         1: begin sender_gap_pct = 52; stall_pct = 0;  end
         2: begin sender_gap_pct = 0;  stall_pct = 52; end
         default: begin sender_gap_pct = 6; stall_pct = 6; end
      endcase
      frame_setups++;
   endtask

   function automatic int pick_origin();
      case ($urandom_range(3))
         0:       return 0;
         1:       return 4095;
         default: return $urandom_range(4095);
      endcase
   endfunction

   // One random frame: mostly a well-formed run of rows, salted with other beats.
   task automatic random_frame();
      logic [DEPTH_W-1:0] depth;
      int img_w, draw_w, draw_h, rows, nbytes, cap, pick;
      if ($urandom_range(9) == 0) begin
         // Widest rows at 1 bpp only, and just a slice of the first row.
         depth  = DEPTH_1;
         img_w  = $urandom_range(1) ? 2048 : 4095;
         draw_w = $urandom_range(1) ? 2048 : 4095;
         draw_h = 1;
         cap    = 40;
      end else begin
         depth  = DEPTH_W'($urandom_range(7));
         img_w  = $urandom_range(12);
         draw_w = ($urandom_range(7) == 0) ? 4095 : $urandom_range(img_w + 2);
         case ($urandom_range(9))
            0:       draw_h = 0;
            1:       draw_h = 4095;
            default: draw_h = $urandom_range(1, 3);
         endcase
         cap = 60;
      end
      set_frame(depth, img_w, draw_w, draw_h, pick_origin(), pick_origin());
      rows   = (draw_h == 0 || draw_h > 3) ? 1 : draw_h;
      nbytes = stride_bytes() * rows + $urandom_range(2);
      if (nbytes > cap) nbytes = cap;
      // Skip the restart now and then so a frame carries over a register change.
      if ($urandom_range(9) != 0) queue_kind(REQ_RESTART, BYTE_W'($urandom));
      for (int i = 0; i < nbytes; i++) begin
         pick = $urandom_range(99);
         if (pick < 8)       queue_kind(REQ_PAL_WRITE, BYTE_W'($urandom));
         else if (pick < 12) queue_kind(REQ_NONE, BYTE_W'($urandom));
         else if (pick < 14) queue_kind(REQ_RESTART, BYTE_W'($urandom));
         queue_kind(REQ_DATA, BYTE_W'($urandom));
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------
   initial begin : run
      int random_start;
      reset_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Out of reset the frame is finished: drop the data byte; ignore the unused kind.
      queue_kind(REQ_DATA, 8'hA5);
      queue_kind(REQ_NONE, BYTE_W'($urandom));
      // Load every palette entry before any lookup can happen; pin the color extremes.
      for (int i = 0; i < DEF_PALETTE_ENTRIES; i++)
         queue_beat(REQ_PAL_WRITE, BYTE_W'($urandom), PAL_IDX_W'(i),
                    (i == 0) ? 24'h000000 :
                    (i == DEF_PALETTE_ENTRIES - 1) ? 24'hFFFFFF : COLOR_W'($urandom));

      // 1 bpp, zero width lifted to one, oversize draw width/height, far origin.
      set_frame(DEPTH_1, 0, 4095, 4095, 4095, 4095);
      queue_kind(REQ_RESTART, 8'h00);
      queue_kind(REQ_DATA, 8'hFF);
      queue_kind(REQ_DATA, 8'h00);
      // 4 bpp, both nibbles.
      set_frame(DEPTH_4, 3, 2, 1, 0, 0);
      queue_kind(REQ_RESTART, 8'h00);
      queue_kind(REQ_DATA, 8'hF0);
      queue_kind(REQ_DATA, 8'h0F);
      // 16 bpp, full-scale RGB565.
      set_frame(DEPTH_16, 1, 1, 2, 17, 4095);
      queue_kind(REQ_RESTART, 8'h00);
      queue_kind(REQ_DATA, 8'hFF);
      queue_kind(REQ_DATA, 8'hFF);
      // 24 bpp: pixel, padding byte, row end finishes the frame, then a dropped byte.
      set_frame(DEPTH_24, 1, 1, 1, 0, 0);
      queue_kind(REQ_RESTART, 8'h00);
      queue_kind(REQ_DATA, 8'h11);
      queue_kind(REQ_DATA, 8'h22);
      queue_kind(REQ_DATA, 8'h33);
      queue_kind(REQ_DATA, 8'h44);
      queue_kind(REQ_DATA, 8'h55);
      // 32 bpp, alpha dropped.
      set_frame(DEPTH_32, 2, 2, 1, 8, 8);
      queue_kind(REQ_RESTART, 8'h00);
      queue_kind(REQ_DATA, 8'h01);
      queue_kind(REQ_DATA, 8'h80);
      queue_kind(REQ_DATA, 8'hFE);
      queue_kind(REQ_DATA, 8'h7F);
      // Unused depth code falls back to 8 bpp.
      set_frame(DEPTH_SPARE, 1, 1, 1, 0, 0);
      queue_kind(REQ_RESTART, 8'h00);
      queue_kind(REQ_DATA, 8'hFF);
      // Zero draw height: restart leaves the frame finished.
      set_frame(DEPTH_8, 1, 1, 0, 0, 0);
      queue_kind(REQ_RESTART, 8'h00);
      queue_kind(REQ_DATA, 8'h00);

      random_start = beats_queued;
      while (beats_queued - random_start < 110) random_frame();

      drain();
      $display("covered %0d register setups over all depth codes and idling styles",
               frame_setups);
      $display("accepted %0d input beats and checked %0d pixel beats",
               beats_accepted, pixels_checked);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("PASS bmp_scanline_pixel_unpacker_top");
      end else begin
         $display("FAIL bmp_scanline_pixel_unpacker_top");
      end
      $finish;
   end

endmodule
`default_nettype wire
